[rtl/core/buddy_block_allocator_unit_assert.svh]
// Assertion macros for the buddy block allocator.
// Used by the top level only; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define BBA_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BBA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/bba_pkg.sv]
// Package for the buddy block allocator: sizes, status codes, controller states.
// No dependencies.
package bba_pkg;

  localparam int unsigned MinBlock    = 64;
  localparam int unsigned LevelCount  = 12;
  localparam int unsigned TopLevel    = 10;
  localparam int unsigned HeaderBytes = 16;

  localparam int unsigned Blocks   = 1 << TopLevel;
  localparam int unsigned Lists    = TopLevel + 1;
  localparam int unsigned IdxW     = $clog2(Blocks);
  localparam int unsigned LvlW     = 4;
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned MinShift = $clog2(MinBlock);

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoMem  = 2'd1,
    StBadAdr = 2'd2,
    StNull   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_POP_RD, S_POP_WAIT, S_SPLIT,
    S_FREE_ADR, S_FREE_REC, S_SRCH_RD, S_SRCH_CMP, S_MOVE_RD, S_MOVE_WR,
    S_PUSH, S_DONE
  } state_e;

  // Smallest level whose block holds the request, raised to at least MinBlock, plus the header.
  function automatic logic [LvlW-1:0] level_for(input logic [16:0] size);
    logic [17:0] need;
    logic [LvlW-1:0] lvl;
    need = ((size < 17'(MinBlock)) ? 18'(MinBlock) : {1'b0, size}) + 18'(HeaderBytes);
    lvl  = LvlW'(LevelCount);
    for (int l = LevelCount - 1; l >= 0; l--) begin
      if ((64'(MinBlock) << l) >= 64'(need)) lvl = LvlW'(l);
    end
    return lvl;
  endfunction

endpackage

[rtl/core/bba_list_mem.sv]
// Free-list store: one row of block indices per level, registered read.
// Depends on bba_pkg.
module bba_list_mem import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [LvlW-1:0]   wlvl_i,
  input  logic [IdxW-1:0]   wpos_i,
  input  logic [IdxW-1:0]   wdata_i,
  input  logic [LvlW-1:0]   rlvl_i,
  input  logic [IdxW-1:0]   rpos_i,
  output logic [IdxW-1:0]   rdata_o
);
  logic [IdxW-1:0] mem [Lists*Blocks];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[{wlvl_i, wpos_i}] <= wdata_i;
    rdata_o <= mem[{rlvl_i, rpos_i}];
  end
endmodule

[rtl/core/bba_rec_mem.sv]
// Allocation record: valid bit and level per block index, registered read.
// Depends on bba_pkg; valid bits cleared by a pass after reset.
module bba_rec_mem import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  logic [LvlW:0]     wdata_i,
  input  logic [IdxW-1:0]   raddr_i,
  output logic [LvlW:0]     rdata_o
);
  logic [LvlW:0] mem [Blocks];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/core/buddy_block_allocator_unit.sv]
// Buddy block allocator top level: controller around the list and record memories.
// Depends on bba_pkg, bba_list_mem, bba_rec_mem and the assertion header.
//
//  channel | dir | tdata (low bit up)                                     | tuser
//  s_axis  | in  | request_size[16:0], address[32:17], pad                | func
//  m_axis  | out | status[1:0], result_address[17:2], level[21:18], pad   | -
//
// Allocate: scan up from the wanted level to the first non-empty list, pop its top block,
// split down to the wanted level listing each upper half; none found: out of memory.
// Free: check the address, read and clear the record, then at each level search the
// buddy's list, remove it by shifting later entries down and merge up; then push the block.
// Null/bad address ends early. After reset a clearing pass over the record memory runs first.
// The final state waits only while the output register holds an untaken result.
`include "buddy_block_allocator_unit_assert.svh"
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // request_size, address, zero pad
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, result_address, block_level, pad
);
  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q [Lists];
  logic            clr_q;
  logic [IdxW-1:0] clr_idx_q;

  logic [15:0]     addr_q;
  logic [LvlW-1:0] want_q, want_d, lvl_q, lvl_d;
  logic [IdxW-1:0] idx_q, idx_d, buddy_q, buddy_d;
  logic [CntW-1:0] pos_q, pos_d;

  status_e         rsts_q, rsts_d;
  logic [15:0]     radr_q, radr_d;
  logic [LvlW-1:0] rlvl_q, rlvl_d;

  logic            ovld_q, ovld_d;
  logic [1:0]      ost_q;
  logic [15:0]     oadr_q;
  logic [LvlW-1:0] olvl_q;

  // memory ports
  logic            lwe;
  logic [LvlW-1:0] lwl;
  logic [IdxW-1:0] lwp, lwd, lrp, lrd;
  logic            rwe;
  logic [IdxW-1:0] rwa, rra;
  logic [LvlW:0]   rwd, rrd;

  bba_list_mem u_list (.clk_i, .we_i(lwe), .wlvl_i(lwl), .wpos_i(lwp), .wdata_i(lwd),
                       .rlvl_i(lvl_q), .rpos_i(lrp), .rdata_o(lrd));
  bba_rec_mem u_rec (.clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd),
                     .raddr_i(rra), .rdata_o(rrd));

  logic            in_fire, out_free, addr_bad, cnt_inc, cnt_dec;
  logic [15:0]     off;
  logic [CntW-1:0] cnt_l;
  logic [IdxW-1:0] low_idx;

  assign out_free      = !ovld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !clr_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign off           = addr_q - 16'(HeaderBytes);
  assign cnt_l         = cnt_q[lvl_q];
  assign low_idx       = (buddy_q < idx_q) ? buddy_q : idx_q;
  assign addr_bad      = (addr_q < 16'(HeaderBytes)) || (off[MinShift-1:0] != '0)
                         || ((off >> MinShift) >= 16'(Blocks));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = s_axis_tuser ? S_FREE_ADR : S_SCAN;
      S_SCAN: begin
        if (want_q > LvlW'(TopLevel)) state_d = S_DONE;
        else if (cnt_l != '0) state_d = S_POP_RD;
        else if (lvl_q == LvlW'(TopLevel)) state_d = S_DONE;
      end
      S_POP_RD:   state_d = S_POP_WAIT;
      S_POP_WAIT: state_d = (lvl_q == want_q) ? S_DONE : S_SPLIT;
      S_SPLIT:    if (lvl_q == want_q) state_d = S_DONE;
      S_FREE_ADR: state_d = (addr_q == '0 || addr_bad) ? S_DONE : S_FREE_REC;
      S_FREE_REC: begin
        if (!rrd[LvlW]) state_d = S_DONE;
        else if (rrd[LvlW-1:0] < LvlW'(TopLevel)) state_d = S_SRCH_RD;
        else state_d = S_PUSH;
      end
      S_SRCH_RD:  state_d = (pos_q >= cnt_l) ? S_PUSH : S_SRCH_CMP;
      S_SRCH_CMP: state_d = (lrd == buddy_q) ? S_MOVE_RD : S_SRCH_RD;
      S_MOVE_RD: begin
        if (pos_q < cnt_l) state_d = S_MOVE_WR;
        else if (lvl_q + 1'b1 < LvlW'(TopLevel)) state_d = S_SRCH_RD;
        else state_d = S_PUSH;
      end
      S_MOVE_WR:  state_d = S_MOVE_RD;
      S_PUSH:     state_d = S_DONE;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    want_d = want_q; lvl_d = lvl_q; idx_d = idx_q; pos_d = pos_q; buddy_d = buddy_q;
    rsts_d = rsts_q; radr_d = radr_q; rlvl_d = rlvl_q;
    lwe = 1'b0; lwl = lvl_q; lwp = '0; lwd = '0; lrp = '0;
    rwe = 1'b0; rwa = idx_q; rwd = '0; rra = off[MinShift +: IdxW];
    cnt_inc = 1'b0; cnt_dec = 1'b0;
    case (state_q)
      S_IDLE: if (in_fire) begin
        want_d = level_for(s_axis_tdata[16:0]);
        lvl_d  = want_d;
        rsts_d = StOk; radr_d = '0; rlvl_d = '0;
      end
      S_SCAN: begin
        if (want_q > LvlW'(TopLevel)) rsts_d = StNoMem;
        else if (cnt_l == '0) begin
          if (lvl_q == LvlW'(TopLevel)) rsts_d = StNoMem;
          else lvl_d = lvl_q + 1'b1;
        end
      end
      S_POP_RD: lrp = IdxW'(cnt_l - 1'b1);
      S_POP_WAIT: begin
        // take the top block; lower halves are carried down without being listed
        cnt_dec = 1'b1;
        idx_d = lrd;
        if (lvl_q == want_q) begin
          rwe = 1'b1; rwa = lrd; rwd = {1'b1, want_q};
          radr_d = 16'({lrd, {MinShift{1'b0}}}) + 16'(HeaderBytes);
          rlvl_d = want_q;
        end else lvl_d = lvl_q - 1'b1;
      end
      S_SPLIT: begin
        // list the upper half at this level
        cnt_inc = 1'b1;
        lwe = 1'b1; lwp = IdxW'(cnt_l); lwd = idx_q | (IdxW'(1) << lvl_q);
        if (lvl_q == want_q) begin
          rwe = 1'b1; rwa = idx_q; rwd = {1'b1, want_q};
          radr_d = 16'({idx_q, {MinShift{1'b0}}}) + 16'(HeaderBytes);
          rlvl_d = want_q;
        end else lvl_d = lvl_q - 1'b1;
      end
      S_FREE_ADR: begin
        idx_d = off[MinShift +: IdxW];
        if (addr_q == '0) rsts_d = StNull;
        else if (addr_bad) rsts_d = StBadAdr;
      end
      S_FREE_REC: begin
        if (!rrd[LvlW]) rsts_d = StBadAdr;
        else begin
          rwe = 1'b1; rwd = '0;
          rlvl_d = rrd[LvlW-1:0]; lvl_d = rrd[LvlW-1:0];
          buddy_d = idx_q ^ (IdxW'(1) << rrd[LvlW-1:0]);
          pos_d = '0;
        end
      end
      S_SRCH_RD:  lrp = pos_q[IdxW-1:0];
      S_SRCH_CMP: pos_d = pos_q + 1'b1;
      S_MOVE_RD: begin
        if (pos_q < cnt_l) lrp = pos_q[IdxW-1:0];
        else begin
          // buddy removed; merge up
          cnt_dec = 1'b1;
          idx_d = low_idx;
          lvl_d = lvl_q + 1'b1;
          buddy_d = low_idx ^ (IdxW'(1) << (lvl_q + 1'b1));
          pos_d = '0;
        end
      end
      S_MOVE_WR: begin
        // shift the entry down over the removed one
        lwe = 1'b1; lwp = IdxW'(pos_q - 1'b1); lwd = lrd; pos_d = pos_q + 1'b1;
      end
      S_PUSH: begin
        cnt_inc = 1'b1;
        lwe = 1'b1; lwp = IdxW'(cnt_l); lwd = idx_q;
      end
      default: ;
    endcase
    if (clr_q) begin
      // invalidate records and seed the top list with block 0
      rwe = 1'b1; rwa = clr_idx_q; rwd = '0;
      lwe = 1'b1; lwl = LvlW'(TopLevel); lwp = '0; lwd = '0;
    end
  end

  assign ovld_d = (ovld_q && !m_axis_tready) || (state_q == S_DONE && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ovld_q <= 1'b0; clr_q <= 1'b1; clr_idx_q <= '0;
      for (int l = 0; l < Lists; l++) cnt_q[l] <= (l == TopLevel) ? CntW'(1) : '0;
    end else begin
      state_q <= state_d; ovld_q <= ovld_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == IdxW'(Blocks - 1)) clr_q <= 1'b0;
      end
      if (cnt_inc) cnt_q[lvl_q] <= cnt_l + 1'b1;
      else if (cnt_dec) cnt_q[lvl_q] <= cnt_l - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) addr_q <= s_axis_tdata[32:17];
    want_q <= want_d; lvl_q <= lvl_d; idx_q <= idx_d; pos_q <= pos_d;
    buddy_q <= buddy_d;
    rsts_q <= rsts_d; radr_q <= radr_d; rlvl_q <= rlvl_d;
    // load the output register only when it is free
    if (state_q == S_DONE && out_free) begin
      ost_q <= rsts_q; oadr_q <= radr_q; olvl_q <= rlvl_q;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, olvl_q, oadr_q, ost_q};

  `BBA_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, !s_axis_tready,
                   "ready while busy")
  `BBA_ASSERT_IMPL(a_top_cnt, clk_i, rst_ni, 1'b1, cnt_q[TopLevel] <= CntW'(1),
                   "top list overflow")
  `BBA_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE && out_free,
                   m_axis_tvalid, "result lost")
  `BBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result changed while waiting")
endmodule
